FILE: design/lbps_pkg.sv
// Package for the LED and beeper blink pattern sequencer: types, codes and pattern table.
package lbps_pkg;

   localparam int PATTERN_COUNT = 13;
   localparam int PHASES_MAX    = 4;
   localparam int ROM_ROWS      = 14;

   localparam logic [3:0] M_RED   = 4'b0001;
   localparam logic [3:0] M_GREEN = 4'b0010;
   localparam logic [3:0] M_BLUE  = 4'b0100;
   localparam logic [3:0] M_BEEP  = 4'b1000;

   localparam logic       ACTION_TICK = 1'b0;
   localparam logic       ACTION_SET  = 1'b1;

   localparam logic [3:0] STATUS_OFF = 4'd0;
   localparam logic [3:0] STATUS_ON  = 4'd1;
   localparam logic [3:0] STATUS_PATTERN_BASE = 4'd2;

   typedef struct packed {
      logic            valid;
      logic [3:0]      colour;
      logic [2:0]      count;
      logic [3:0][7:0] thr;
      logic [7:0]      last;
   } lbps_row_type;

   function automatic lbps_row_type make_row(input logic [3:0] colour, input int unsigned count,
                                             input logic [7:0] t0, input logic [7:0] t1,
                                             input logic [7:0] t2, input logic [7:0] t3);
      lbps_row_type r;
      int unsigned  cnt;
      cnt = count;
      if (cnt > PHASES_MAX) cnt = PHASES_MAX;
      if (cnt > 4) cnt = 4;
      if (cnt == 0) cnt = 1;
      r.valid  = 1'b1;
      r.colour = colour;
      r.count  = 3'(cnt);
      r.thr[0] = t0;
      r.thr[1] = t1;
      r.thr[2] = t2;
      r.thr[3] = t3;
      r.last   = r.thr[2'(cnt - 1)];
      return r;
   endfunction

   // Row lookup by status code; codes without a pattern come back invalid.
   function automatic lbps_row_type pattern_row(input logic [3:0] status);
      lbps_row_type r;
      logic [3:0]   idx;
      idx = status - STATUS_PATTERN_BASE;
      unique case (idx)
         4'd0:    r = make_row(M_GREEN, 4, 8'd3, 8'd6, 8'd9, 8'd19);
         4'd1:    r = make_row(M_GREEN, 4, 8'd2, 8'd4, 8'd6, 8'd18);
         4'd2:    r = make_row(M_GREEN, 4, 8'd4, 8'd8, 8'd12, 8'd16);
         4'd3:    r = make_row(M_GREEN, 4, 8'd2, 8'd4, 8'd6, 8'd8);
         4'd4:    r = make_row(M_GREEN, 4, 8'd3, 8'd6, 8'd9, 8'd12);
         4'd5:    r = make_row(M_GREEN, 4, 8'd6, 8'd12, 8'd18, 8'd24);
         4'd6:    r = make_row(M_GREEN, 4, 8'd10, 8'd20, 8'd30, 8'd40);
         4'd7:    r = make_row(M_BEEP, 2, 8'd10, 8'd30, 8'd0, 8'd0);
         4'd8:    r = make_row(M_RED | M_BEEP, 4, 8'd3, 8'd10, 8'd13, 8'd20);
         4'd9:    r = make_row(M_RED, 4, 8'd3, 8'd6, 8'd9, 8'd12);
         4'd10:   r = make_row(M_GREEN, 4, 8'd2, 8'd12, 8'd14, 8'd24);
         4'd11:   r = make_row(M_BLUE, 4, 8'd6, 8'd12, 8'd18, 8'd24);
         4'd12:   r = make_row(M_RED | M_BEEP, 4, 8'd3, 8'd6, 8'd9, 8'd12);
         4'd13:   r = make_row(M_RED | M_GREEN, 4, 8'd2, 8'd4, 8'd6, 8'd18);
         default: r = '0;
      endcase
      if ((status < STATUS_PATTERN_BASE) || (32'(idx) >= PATTERN_COUNT) ||
          (32'(idx) >= ROM_ROWS)) begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: design/led_beep_blink_pattern_sequencer_core.sv
// Top level of the LED and beeper blink pattern sequencer.
// An accepted req word gives its rsp word in the next cycle.
// Throughput: one word per cycle while rsp is not stalled; the pattern row is registered from the table,
// addressed by the next status, so the following word always sees its row.
// Reset clears status, counters, output levels, work mode and the rsp valid flag.
// The csr port is always ready and registers a write into the work mode.
module led_beep_blink_pattern_sequencer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [3:0] req_new_status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_red_on,
   output logic       rsp_green_on,
   output logic       rsp_blue_on,
   output logic       rsp_beep_on,
   output logic [3:0] rsp_current_status,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [3:0] csr_work_mode
);
   import lbps_pkg::*;

   logic [3:0]   work_mode_ff;
   logic [3:0]   status_ff, status_in;
   logic [7:0]   tick_ff, tick_in;
   logic [1:0]   phase_ff, phase_in;
   logic [3:0]   levels_ff, levels_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [3:0]   rsp_levels_ff;
   logic [3:0]   rsp_status_ff;
   lbps_row_type row_ff;
   logic         accept;

   logic [2:0]   ph;
   logic [2:0]   ph_next;
   logic [7:0]   tick_inc;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      status_in = status_ff;
      tick_in   = tick_ff;
      phase_in  = phase_ff;
      levels_in = levels_ff;
      ph        = {1'b0, phase_ff};
      ph_next   = '0;
      tick_inc  = tick_ff + 8'd1;
      if (ph >= row_ff.count) ph = '0;
      if (accept) begin
         if (req_action == ACTION_SET) begin
            if (status_ff != req_new_status) begin
               status_in = req_new_status;
               tick_in   = '0;
               phase_in  = '0;
            end
         end else if (status_ff == STATUS_OFF) begin
            levels_in = '0;
         end else if (status_ff == STATUS_ON) begin
            levels_in = levels_ff | work_mode_ff;
         end else if (!row_ff.valid) begin
            levels_in = '0;
         end else begin
            if (tick_ff < row_ff.thr[ph[1:0]]) begin
               levels_in = ph[0] ? 4'b0000 : (levels_ff | row_ff.colour);
               phase_in  = ph[1:0];
            end else begin
               ph_next  = ph + 3'd1;
               if (ph_next >= row_ff.count) ph_next = '0;
               phase_in = ph_next[1:0];
            end
            tick_in = tick_inc;
            if (tick_inc >= row_ff.last) begin
               tick_in  = '0;
               phase_in = '0;
            end
         end
      end
      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_mode_ff <= '0;
         status_ff    <= STATUS_OFF;
         tick_ff      <= '0;
         phase_ff     <= '0;
         levels_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) work_mode_ff <= csr_work_mode;
         status_ff    <= status_in;
         tick_ff      <= tick_in;
         phase_ff     <= phase_in;
         levels_ff    <= levels_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pattern table read, registered, addressed by next status
   always_ff @(posedge clock) begin
      row_ff <= pattern_row(status_in);
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_levels_ff <= levels_in;
         rsp_status_ff <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_red_on         = rsp_levels_ff[0];
   assign rsp_green_on       = rsp_levels_ff[1];
   assign rsp_blue_on        = rsp_levels_ff[2];
   assign rsp_beep_on        = rsp_levels_ff[3];
   assign rsp_current_status = rsp_status_ff;

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted word produced no rsp word");

   a_status_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == status_ff))
      else $error("rsp status differs from stored status");

   a_set_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACTION_SET && req_new_status != status_ff)
      |=> (tick_ff == 8'd0 && phase_ff == 2'd0))
      else $error("status change did not restart counters");

   a_off_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACTION_TICK && status_ff == STATUS_OFF)
      |=> (rsp_levels_ff == 4'b0000))
      else $error("off status left an output on");

endmodule
